// File: src/opft_pkg.sv
// Shared types and constants for the pulse-width keyed frame transmitter.
// No dependencies; every other file in src except opft_checker uses scoped names.
`default_nettype none

package opft_pkg;

  // Register map; register i sits at byte address 4*i
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ONE_WIDTH    = 2'd0,
    REG_ZERO_WIDTH   = 2'd1,
    REG_REPEAT_COUNT = 2'd2,
    REG_GAP_TICKS    = 2'd3
  } reg_idx_e;

  localparam logic [11:0] ONE_WIDTH_RST    = 12'd600;
  localparam logic [11:0] ZERO_WIDTH_RST   = 12'd400;
  localparam logic [3:0]  REPEAT_COUNT_RST = 4'd8;
  localparam logic [15:0] GAP_TICKS_RST    = 16'd10000;

  // Frame layout
  localparam logic [7:0] CHECKSUM_SEED = 8'h06;
  localparam int unsigned EXT_FLAG_BIT = 5;
  localparam logic [6:0] SYNC_LAST_POS = 7'd12;  // twelve zeros, then a one here
  localparam logic [2:0] BYTES_BASE    = 3'd5;
  localparam logic [2:0] BYTES_EXT     = 3'd6;
  localparam logic [3:0] PARITY_SLOT   = 4'd8;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [11:0] one_width;
    logic [11:0] zero_width;
    logic [3:0]  repeat_count;
    logic [15:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] house;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [7:0]  ext_data;
    logic [7:0]  checksum;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic start_rejected;
    logic all_done;
  } res_t;

endpackage

`default_nettype wire

// File: src/opft_cfg.sv
// APB-style register file: one_width, zero_width, repeat_count, gap_ticks.
// Depends on opft_pkg for the register map and reset values.
`default_nettype none

module opft_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [opft_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [opft_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [opft_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output opft_pkg::cfg_t                        cfg_o
);

  opft_pkg::cfg_t     cfg_q;
  opft_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = opft_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_width    <= opft_pkg::ONE_WIDTH_RST;
      cfg_q.zero_width   <= opft_pkg::ZERO_WIDTH_RST;
      cfg_q.repeat_count <= opft_pkg::REPEAT_COUNT_RST;
      cfg_q.gap_ticks    <= opft_pkg::GAP_TICKS_RST;
    end else if (wr_en) begin
      case (idx)
        opft_pkg::REG_ONE_WIDTH:    cfg_q.one_width    <= pwdata[11:0];
        opft_pkg::REG_ZERO_WIDTH:   cfg_q.zero_width   <= pwdata[11:0];
        opft_pkg::REG_REPEAT_COUNT: cfg_q.repeat_count <= pwdata[3:0];
        opft_pkg::REG_GAP_TICKS:    cfg_q.gap_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      opft_pkg::REG_ONE_WIDTH:    prdata = {20'd0, cfg_q.one_width};
      opft_pkg::REG_ZERO_WIDTH:   prdata = {20'd0, cfg_q.zero_width};
      opft_pkg::REG_REPEAT_COUNT: prdata = {28'd0, cfg_q.repeat_count};
      opft_pkg::REG_GAP_TICKS:    prdata = {16'd0, cfg_q.gap_ticks};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/opft_front.sv
// Front end: accepts input words, tags starts, precomputes the frame checksum
// and holds words in a two-entry queue for the back end. Depends on opft_pkg.
`default_nettype none

module opft_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           req_type_i,
  input  wire logic [15:0]    house_i,
  input  wire logic [7:0]     address_i,
  input  wire logic [7:0]     command_i,
  input  wire logic [7:0]     ext_data_i,
  output logic                q_valid_o,
  output opft_pkg::item_t     q_item_o,
  input  wire logic           q_pop_i
);

  opft_pkg::item_t                    mem_q [opft_pkg::Q_DEPTH];
  opft_pkg::item_t                    item_in;
  logic [opft_pkg::Q_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [opft_pkg::Q_CNT_W-1:0]       cnt_q, cnt_d;
  logic                               push, pop;
  logic [7:0]                         csum;

  // 6 plus every byte sent before the checksum, mod 256
  always_comb begin
    csum = opft_pkg::CHECKSUM_SEED + house_i[15:8] + house_i[7:0] + address_i + command_i;
    if (command_i[opft_pkg::EXT_FLAG_BIT]) begin
      csum = csum + ext_data_i;
    end
  end

  always_comb begin
    item_in.start    = req_type_i;
    item_in.house    = house_i;
    item_in.address  = address_i;
    item_in.command  = command_i;
    item_in.ext_data = ext_data_i;
    item_in.checksum = csum;
  end

  assign in_stall_o = (cnt_q == opft_pkg::Q_CNT_W'(opft_pkg::Q_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: src/opft_back.sv
// Back end: frame sequencer that runs one queued word per cycle unless the
// output stalls, drives the keyed pin level and holds the result word in an output register. Uses opft_pkg.
`default_nettype none

module opft_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire opft_pkg::cfg_t cfg_i,
  input  wire logic           q_valid_i,
  input  wire opft_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output opft_pkg::res_t      res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BITS = 2'd1,
    PH_GAP  = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [6:0]      pos_q, pos_d;
  logic [2:0]      byte_q, byte_d;   // byte index within the data section
  logic [3:0]      slot_q, slot_d;   // bit slot within the byte, 8 is parity
  logic            half_q, half_d;
  logic [15:0]     tick_q, tick_d;
  logic [3:0]      reps_q, reps_d;
  logic            pin_q, pin_d;
  logic [15:0]     house_q, house_d;
  logic [7:0]      addr_q, addr_d, cmd_q, cmd_d, ext_q, ext_d, csum_q, csum_d;
  logic            out_valid_q;
  opft_pkg::res_t  res_q, res_d;

  logic            busy, step;
  logic            has_ext;
  logic [2:0]      byte_cnt;
  logic [7:0]      cur_byte;
  logic            bit_val;
  logic [11:0]     width_sel, width_eff;
  logic [15:0]     tick_inc;
  logic            in_data, last_bit;
  logic [3:0]      reps_dec;

  assign busy    = (phase_q == PH_BITS) || (phase_q == PH_GAP);
  assign step    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = step;

  assign has_ext  = cmd_q[opft_pkg::EXT_FLAG_BIT];
  assign byte_cnt = has_ext ? opft_pkg::BYTES_EXT : opft_pkg::BYTES_BASE;
  assign in_data  = (pos_q > opft_pkg::SYNC_LAST_POS);
  assign last_bit = in_data && (byte_q >= byte_cnt);

  always_comb begin
    case (byte_q)
      3'd0:    cur_byte = house_q[15:8];
      3'd1:    cur_byte = house_q[7:0];
      3'd2:    cur_byte = addr_q;
      3'd3:    cur_byte = cmd_q;
      3'd4:    cur_byte = has_ext ? ext_q : csum_q;
      default: cur_byte = csum_q;
    endcase
  end

  always_comb begin
    if (pos_q < opft_pkg::SYNC_LAST_POS) begin
      bit_val = 1'b0;
    end else if (pos_q == opft_pkg::SYNC_LAST_POS) begin
      bit_val = 1'b1;
    end else if (last_bit) begin
      bit_val = 1'b0;
    end else if (slot_q == opft_pkg::PARITY_SLOT) begin
      bit_val = ^cur_byte;
    end else begin
      bit_val = cur_byte[3'(4'd7 - slot_q)];
    end
  end

  assign width_sel = bit_val ? cfg_i.one_width : cfg_i.zero_width;
  assign width_eff = (width_sel == '0) ? 12'd1 : width_sel;
  assign tick_inc  = tick_q + 16'd1;
  assign reps_dec  = reps_q - 4'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    byte_d  = byte_q;
    slot_d  = slot_q;
    half_d  = half_q;
    tick_d  = tick_q;
    reps_d  = reps_q;
    pin_d   = pin_q;
    house_d = house_q;
    addr_d  = addr_q;
    cmd_d   = cmd_q;
    ext_d   = ext_q;
    csum_d  = csum_q;
    res_d   = '0;

    if (q_item_i.start) begin
      if (busy) begin
        res_d.start_rejected = 1'b1;
      end else begin
        house_d = q_item_i.house;
        addr_d  = q_item_i.address;
        cmd_d   = q_item_i.command;
        ext_d   = q_item_i.ext_data;
        csum_d  = q_item_i.checksum;
        reps_d  = (cfg_i.repeat_count == '0) ? 4'd1 : cfg_i.repeat_count;
        phase_d = PH_BITS;
        pos_d   = '0;
        byte_d  = '0;
        slot_d  = '0;
        half_d  = 1'b0;
        tick_d  = '0;
        pin_d   = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_BITS: begin
          tick_d = tick_inc;
          if (tick_inc >= {4'd0, width_eff}) begin
            tick_d = '0;
            if (!half_q) begin
              half_d = 1'b1;
              pin_d  = 1'b0;
            end else if (last_bit) begin
              if (cfg_i.gap_ticks != '0) begin
                phase_d = PH_GAP;
                half_d  = 1'b0;
                pin_d   = 1'b0;
              end else begin
                reps_d = reps_dec;
                if (reps_dec == '0) begin
                  phase_d = PH_IDLE;
                  pos_d   = '0;
                  half_d  = 1'b0;
                  pin_d   = 1'b0;
                  res_d.all_done = 1'b1;
                end else begin
                  phase_d = PH_BITS;
                  pos_d   = '0;
                  byte_d  = '0;
                  slot_d  = '0;
                  half_d  = 1'b0;
                  pin_d   = 1'b1;
                end
              end
            end else begin
              pos_d  = pos_q + 7'd1;
              half_d = 1'b0;
              pin_d  = 1'b1;
              // advance byte and slot once the sync is behind us
              if (pos_q == opft_pkg::SYNC_LAST_POS) begin
                byte_d = '0;
                slot_d = '0;
              end else if (in_data) begin
                if (slot_q == opft_pkg::PARITY_SLOT) begin
                  slot_d = '0;
                  byte_d = byte_q + 3'd1;
                end else begin
                  slot_d = slot_q + 4'd1;
                end
              end
            end
          end
        end
        PH_GAP: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.gap_ticks) begin
            tick_d = '0;
            reps_d = reps_dec;
            if (reps_dec == '0) begin
              phase_d = PH_IDLE;
              pos_d   = '0;
              half_d  = 1'b0;
              pin_d   = 1'b0;
              res_d.all_done = 1'b1;
            end else begin
              phase_d = PH_BITS;
              pos_d   = '0;
              byte_d  = '0;
              slot_d  = '0;
              half_d  = 1'b0;
              pin_d   = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          pin_d   = 1'b0;
        end
      endcase
    end

    res_d.pin_level = pin_d;
    res_d.busy_res  = (phase_d == PH_BITS) || (phase_d == PH_GAP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      byte_q      <= '0;
      slot_q      <= '0;
      half_q      <= 1'b0;
      tick_q      <= '0;
      reps_q      <= '0;
      pin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        byte_q  <= byte_d;
        slot_q  <= slot_d;
        half_q  <= half_d;
        tick_q  <= tick_d;
        reps_q  <= reps_d;
        pin_q   <= pin_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      house_q <= house_d;
      addr_q  <= addr_d;
      cmd_q   <= cmd_d;
      ext_q   <= ext_d;
      csum_q  <= csum_d;
      res_q   <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: src/ook_pulse_frame_transmitter_unit.sv
// Top level of the pulse-width keyed frame transmitter.
// Instantiates opft_cfg, opft_front and opft_back; types come from opft_pkg.
`default_nettype none

// One input word per clock: a tick word (req_type 0) advances the frame timer
// by one microsecond, a start word (req_type 1) loads house code, address,
// command and extension byte and begins a frame. Every accepted word yields
// exactly one result word with the pin level after it, the busy flag, a start
// rejected flag and the all done flag. Words are taken one per cycle with no
// bubbles while the input is not stalled; each word passes through the queue
// and then the result register before its result appears. A two-entry
// queue between the input stage and the frame sequencer absorbs output stalls,
// and the input stalls only once that queue is full. Registers sit at byte
// addresses 0, 4, 8 and 12 and must be written only while the block is idle.
module ook_pulse_frame_transmitter_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [opft_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [opft_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [opft_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic [15:0]                      house_i,
  input  wire logic [7:0]                       address_i,
  input  wire logic [7:0]                       command_i,
  input  wire logic [7:0]                       ext_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  pin_level_o,
  output logic                                  busy_res_o,
  output logic                                  start_rejected_o,
  output logic                                  all_done_o
);

  opft_pkg::cfg_t  cfg;
  opft_pkg::item_t q_item;
  opft_pkg::res_t  res;
  logic            q_valid, q_pop;

  opft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  opft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .house_i    (house_i),
    .address_i  (address_i),
    .command_i  (command_i),
    .ext_data_i (ext_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  opft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign pin_level_o      = res.pin_level;
  assign busy_res_o       = res.busy_res;
  assign start_rejected_o = res.start_rejected;
  assign all_done_o       = res.all_done;

endmodule

`default_nettype wire

// File: src/opft_checker.sv
// Port-level checker for the frame transmitter, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module opft_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic pin_level_o,
  input wire logic busy_res_o,
  input wire logic start_rejected_o,
  input wire logic all_done_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o
      && $stable(pin_level_o) && $stable(busy_res_o)
      && $stable(start_rejected_o) && $stable(all_done_o))
    else $error("result word changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_done_o |-> !busy_res_o && !pin_level_o && !start_rejected_o)
    else $error("finish word shows activity");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_rejected_o |-> busy_res_o && !all_done_o)
    else $error("start rejected while not busy");

  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !pin_level_o)
    else $error("pin high while idle");

endmodule

bind ook_pulse_frame_transmitter_unit opft_checker u_opft_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .pin_level_o      (pin_level_o),
  .busy_res_o       (busy_res_o),
  .start_rejected_o (start_rejected_o),
  .all_done_o       (all_done_o)
);

`default_nettype wire
